[design/fbce_pkg.sv]
// Shared types and constants of the Fischer-Burmeister constraint evaluator.
// No dependencies; every other design file imports this package.
`default_nettype none
package fbce_pkg;

   localparam int DATA_W = 32;
   localparam int THR_W  = 17;
   localparam logic [THR_W-1:0] THR_RESET = 17'd1;
   localparam logic signed [DATA_W-1:0] MAX32 = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] MIN32 = 32'sh8000_0000;

   typedef struct packed {
      logic signed [DATA_W-1:0] separation;
      logic signed [DATA_W-1:0] multiplier;
      logic                     is_spring;
      logic [DATA_W-2:0]        stiffness;
   } fbce_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] residual;
      logic signed [DATA_W-1:0] scale;
      logic signed [DATA_W-1:0] diagonal;
      logic                     saturated;
   } fbce_rsp_type;

   // Sideband carried through the square root pipeline.
   typedef struct packed {
      logic signed [DATA_W-1:0] s;
      logic signed [DATA_W-1:0] g;
      logic                     spring;
      logic [DATA_W-2:0]        k;
      logic                     near;
   } fbce_sq_side_type;

   // Sideband carried through the divider pipeline.
   typedef struct packed {
      logic signed [DATA_W-1:0] s;
      logic signed [DATA_W-1:0] g;
      logic                     spring;
      logic                     kzero;
      logic                     near;
      logic [DATA_W-1:0]        r;
   } fbce_dv_side_type;

endpackage
`default_nettype wire

[design/fbce_sqrt.sv]
// Pipelined restoring integer square root, one result bit per stage.
// Depends on fbce_pkg for data width and sideband type.
`default_nettype none
module fbce_sqrt
   import fbce_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  wire logic [2*DATA_W-1:0]     in_x,
   input  wire fbce_sq_side_type        in_side,
   output logic                         out_valid,
   output logic [DATA_W-1:0]            out_root,
   output fbce_sq_side_type             out_side
);

   localparam int NS = DATA_W;
   localparam int RW = DATA_W + 3;

   logic                  valid_ff [NS];
   logic [RW-1:0]         rem_ff   [NS];
   logic [DATA_W-1:0]     root_ff  [NS];
   logic [2*DATA_W-1:0]   x_ff     [NS];
   fbce_sq_side_type      side_ff  [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic                valid_p;
      logic [RW-1:0]       rem_p;
      logic [DATA_W-1:0]   root_p;
      logic [2*DATA_W-1:0] x_p;
      fbce_sq_side_type    side_p;
      logic [RW-1:0]       rem_sh;
      logic [RW-1:0]       trial;
      logic                ge;

      if (k == 0) begin : g_first
         assign valid_p = in_valid;
         assign rem_p   = '0;
         assign root_p  = '0;
         assign x_p     = in_x;
         assign side_p  = in_side;
      end else begin : g_next
         assign valid_p = valid_ff[k-1];
         assign rem_p   = rem_ff[k-1];
         assign root_p  = root_ff[k-1];
         assign x_p     = x_ff[k-1];
         assign side_p  = side_ff[k-1];
      end

      assign rem_sh = {rem_p[RW-3:0], x_p[2*DATA_W-1 -: 2]};
      assign trial  = {1'b0, root_p, 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? (rem_sh - trial) : rem_sh;
            root_ff[k] <= {root_p[DATA_W-2:0], ge};
            x_ff[k]    <= {x_p[2*DATA_W-3:0], 2'b00};
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_root  = root_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule
`default_nettype wire

[design/fbce_div.sv]
// Pipelined two-lane restoring divider sharing one divisor, one bit per stage.
// Depends on fbce_pkg for data width and sideband type.
`default_nettype none
module fbce_div
   import fbce_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic [DATA_W+FRAC_BITS-1:0]   in_num_a,
   input  wire logic [DATA_W+FRAC_BITS-1:0]   in_num_b,
   input  wire logic [DATA_W-1:0]             in_den,
   input  wire fbce_dv_side_type              in_side,
   output logic                               out_valid,
   output logic [DATA_W+FRAC_BITS-1:0]        out_quo_a,
   output logic [DATA_W+FRAC_BITS-1:0]        out_quo_b,
   output fbce_dv_side_type                   out_side
);

   localparam int NW = DATA_W + FRAC_BITS;

   logic              valid_ff [NW];
   logic [DATA_W-1:0] rema_ff  [NW];
   logic [DATA_W-1:0] remb_ff  [NW];
   logic [NW-1:0]     qa_ff    [NW];
   logic [NW-1:0]     qb_ff    [NW];
   logic [NW-1:0]     na_ff    [NW];
   logic [NW-1:0]     nb_ff    [NW];
   logic [DATA_W-1:0] den_ff   [NW];
   fbce_dv_side_type  side_ff  [NW];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic              valid_p;
      logic [DATA_W-1:0] rema_p, remb_p, den_p;
      logic [NW-1:0]     qa_p, qb_p, na_p, nb_p;
      fbce_dv_side_type  side_p;
      logic [DATA_W:0]   sha, shb, dx;
      logic              gea, geb;

      if (k == 0) begin : g_first
         assign valid_p = in_valid;
         assign rema_p  = '0;
         assign remb_p  = '0;
         assign qa_p    = '0;
         assign qb_p    = '0;
         assign na_p    = in_num_a;
         assign nb_p    = in_num_b;
         assign den_p   = in_den;
         assign side_p  = in_side;
      end else begin : g_next
         assign valid_p = valid_ff[k-1];
         assign rema_p  = rema_ff[k-1];
         assign remb_p  = remb_ff[k-1];
         assign qa_p    = qa_ff[k-1];
         assign qb_p    = qb_ff[k-1];
         assign na_p    = na_ff[k-1];
         assign nb_p    = nb_ff[k-1];
         assign den_p   = den_ff[k-1];
         assign side_p  = side_ff[k-1];
      end

      assign dx  = {1'b0, den_p};
      assign sha = {rema_p, na_p[NW-1]};
      assign shb = {remb_p, nb_p[NW-1]};
      assign gea = (sha >= dx);
      assign geb = (shb >= dx);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rema_ff[k] <= gea ? DATA_W'(sha - dx) : DATA_W'(sha);
            remb_ff[k] <= geb ? DATA_W'(shb - dx) : DATA_W'(shb);
            qa_ff[k]   <= {qa_p[NW-2:0], gea};
            qb_ff[k]   <= {qb_p[NW-2:0], geb};
            na_ff[k]   <= {na_p[NW-2:0], 1'b0};
            nb_ff[k]   <= {nb_p[NW-2:0], 1'b0};
            den_ff[k]  <= den_p;
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign out_quo_a = qa_ff[NW-1];
   assign out_quo_b = qb_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule
`default_nettype wire

[design/fischer_burmeister_constraint_eval_top.sv]
// Top level of the Fischer-Burmeister constraint evaluator.
// Depends on fbce_pkg, fbce_sqrt and fbce_div.
//
// Usage:
//   req channel (req_valid/req_stall/req_payload): one constraint per transfer,
//     separation s, multiplier g, spring flag and stiffness k, Q16.16.
//   rsp channel (rsp_valid/rsp_stall/rsp_payload): one result per request with
//     residual, scale, diagonal and the saturated flag, in request order.
//   csr channel (csr_valid/csr_ready/csr_data): writes the near-zero threshold;
//     always ready. Write it only while no request is in flight.
// Throughput: one transfer per cycle while the output is not held.
// Pipeline: from request transfer to result transfer, a Q16.16 request passes
//   the input register, squaring, sum, 32 square root stages, one divider
//   stage per quotient bit, and the output register.
// Stall: while rsp_valid is high and rsp_stall is asserted, the whole pipeline
//   holds and req_stall is raised; nothing is dropped or repeated.
// Reset: synchronous, clears all stage valid bits and sets the threshold to 1.
`default_nettype none
module fischer_burmeister_constraint_eval_top
   import fbce_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire fbce_req_type     req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output fbce_rsp_type          rsp_payload,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [THR_W-1:0] csr_data
);

   localparam int QW = DATA_W + FRAC_BITS;
   localparam int EW = QW + 2;
   localparam logic [DATA_W-1:0]   ONE_U = DATA_W'(64'd1 << FRAC_BITS);
   localparam logic signed [EW-1:0] ONE_E = EW'(64'd1 << FRAC_BITS);
   localparam logic signed [EW-1:0] MAX_E = EW'(MAX32);
   localparam logic signed [EW-1:0] MIN_E = EW'(MIN32);

   // Global advance: every stage moves unless the output is held.
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   // Threshold register.
   logic [THR_W-1:0] thr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_data;
      end
   end

   // Stage 0: register the request.
   logic         v0_ff;
   fbce_req_type p0_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff <= req_payload;
      end
   end

   // Stage 1: magnitudes, squares, near-origin test.
   logic [DATA_W-1:0] ms, mg;
   assign ms = p0_ff.separation[DATA_W-1] ? DATA_W'(-p0_ff.separation) : p0_ff.separation;
   assign mg = p0_ff.multiplier[DATA_W-1] ? DATA_W'(-p0_ff.multiplier) : p0_ff.multiplier;

   logic                v1_ff;
   logic [2*DATA_W-1:0] sqs_ff, sqg_ff;
   fbce_sq_side_type    side1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         sqs_ff          <= ms * ms;
         sqg_ff          <= mg * mg;
         side1_ff.s      <= p0_ff.separation;
         side1_ff.g      <= p0_ff.multiplier;
         side1_ff.spring <= p0_ff.is_spring;
         side1_ff.k      <= p0_ff.stiffness;
         side1_ff.near   <= (ms < DATA_W'(thr_ff)) && (mg < DATA_W'(thr_ff));
      end
   end

   // Stage 2: sum of squares.
   logic                v2_ff;
   logic [2*DATA_W-1:0] sum_ff;
   fbce_sq_side_type    side2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff   <= sqs_ff + sqg_ff;
         side2_ff <= side1_ff;
      end
   end

   // Square root pipeline.
   logic              sq_valid;
   logic [DATA_W-1:0] sq_root;
   fbce_sq_side_type  sq_side;

   fbce_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v2_ff),
      .in_x      (sum_ff),
      .in_side   (side2_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Divider operands: spring divides g and 1 by k, collision s and g by r.
   logic [DATA_W-1:0] mag_s, mag_g, num_a, num_b, den;
   fbce_dv_side_type  dv_in_side;
   assign mag_s = sq_side.s[DATA_W-1] ? DATA_W'(-sq_side.s) : sq_side.s;
   assign mag_g = sq_side.g[DATA_W-1] ? DATA_W'(-sq_side.g) : sq_side.g;
   assign num_a = sq_side.spring ? mag_g : mag_s;
   assign num_b = sq_side.spring ? ONE_U : mag_g;
   assign den   = sq_side.spring ? {1'b0, sq_side.k} : sq_root;

   assign dv_in_side.s      = sq_side.s;
   assign dv_in_side.g      = sq_side.g;
   assign dv_in_side.spring = sq_side.spring;
   assign dv_in_side.kzero  = (sq_side.k == '0);
   assign dv_in_side.near   = sq_side.near;
   assign dv_in_side.r      = sq_root;

   logic             dv_valid;
   logic [QW-1:0]    quo_a, quo_b;
   fbce_dv_side_type dv_side;

   fbce_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_num_a  ({num_a, FRAC_BITS'(0)}),
      .in_num_b  ({num_b, FRAC_BITS'(0)}),
      .in_den    (den),
      .in_side   (dv_in_side),
      .out_valid (dv_valid),
      .out_quo_a (quo_a),
      .out_quo_b (quo_b),
      .out_side  (dv_side)
   );

   // Final stage: apply signs, combine, saturate.
   logic signed [EW-1:0] qa_e, qb_e, s_e, g_e, r_e;
   logic signed [EW-1:0] res_w, scl_w, dia_w;
   logic                 a_neg, b_neg, near_col;
   assign a_neg    = dv_side.spring ? dv_side.g[DATA_W-1] : dv_side.s[DATA_W-1];
   assign b_neg    = dv_side.spring ? 1'b0 : dv_side.g[DATA_W-1];
   assign qa_e     = a_neg ? -$signed({2'b00, quo_a}) : $signed({2'b00, quo_a});
   assign qb_e     = b_neg ? -$signed({2'b00, quo_b}) : $signed({2'b00, quo_b});
   assign s_e      = EW'(dv_side.s);
   assign g_e      = EW'(dv_side.g);
   assign r_e      = $signed(EW'(dv_side.r));
   assign near_col = dv_side.near || (dv_side.r == '0);

   always_comb begin
      if (dv_side.spring) begin
         res_w = s_e + qa_e;
         scl_w = ONE_E;
         dia_w = qb_e;
      end else begin
         res_w = s_e + g_e - r_e;
         scl_w = near_col ? '0 : ONE_E - qa_e;
         dia_w = near_col ? ONE_E : ONE_E - qb_e;
      end
   end

   function automatic logic [DATA_W:0] sat_fn(input logic signed [EW-1:0] v);
      logic [DATA_W:0] o;
      if (v > MAX_E) begin
         o = {1'b1, MAX32};
      end else if (v < MIN_E) begin
         o = {1'b1, MIN32};
      end else begin
         o = {1'b0, v[DATA_W-1:0]};
      end
      return o;
   endfunction

   logic [DATA_W:0] res_s, scl_s, dia_s;
   fbce_rsp_type    rsp_in;
   assign res_s = sat_fn(res_w);
   assign scl_s = sat_fn(scl_w);
   assign dia_s = sat_fn(dia_w);

   always_comb begin
      rsp_in.scale = scl_s[DATA_W-1:0];
      if (dv_side.spring && dv_side.kzero) begin
         rsp_in.diagonal  = MAX32;
         rsp_in.saturated = 1'b1;
         if (dv_side.g[DATA_W-1]) begin
            rsp_in.residual = MIN32;
         end else if (dv_side.g != '0) begin
            rsp_in.residual = MAX32;
         end else begin
            rsp_in.residual = dv_side.s;
         end
      end else begin
         rsp_in.residual  = res_s[DATA_W-1:0];
         rsp_in.diagonal  = dia_s[DATA_W-1:0];
         rsp_in.saturated = res_s[DATA_W] | scl_s[DATA_W] | dia_s[DATA_W];
      end
   end

   // Output register.
   logic         rsp_valid_ff;
   fbce_rsp_type rsp_payload_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A held pipeline keeps the divider's last stage in place.
   a_hold_div: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(dv_valid))
      else $error("divider stage moved during stall");

   // A collision near the origin yields scale zero and diagonal one.
   a_near_origin: assert property (@(posedge clock) disable iff (reset)
      (en && dv_valid && !dv_side.spring && dv_side.near) |=>
      (rsp_valid && rsp_payload.scale == '0 && rsp_payload.diagonal == DATA_W'(ONE_U)))
      else $error("near-origin collision result wrong");
`endif

endmodule
`default_nettype wire

[verif/tb_top.sv]
// Self-checking bench for the Fischer-Burmeister constraint evaluator.
// Depends on fbce_pkg and fischer_burmeister_constraint_eval_top.
`timescale 1ns / 1ps
module tb_top;
   import fbce_pkg::*;

   localparam int FRAC = 16;
   localparam int LATENCY = 84;
   localparam longint ONE_Q = 64'sd1 << FRAC;
   localparam longint MAX_Q = 64'sd2147483647;
   localparam longint MIN_Q = -64'sd2147483648;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   fbce_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   fbce_rsp_type rsp_payload;
   logic csr_valid = 0;
   logic csr_ready;
   logic [THR_W-1:0] csr_data = '0;

   // Bench copy of the threshold register.
   logic [THR_W-1:0] threshold_q = THR_RESET;

   fbce_rsp_type pending_results[$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatches = 0;
   int results_seen = 0;
   int items_sent = 0;

   fischer_burmeister_constraint_eval_top #(.FRAC_BITS(FRAC)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic longint clip32(longint v, inout bit flag);
      if (v > MAX_Q) begin
         flag = 1;
         return MAX_Q;
      end
      if (v < MIN_Q) begin
         flag = 1;
         return MIN_Q;
      end
      return v;
   endfunction

   // Fixed-point quotient, truncated toward zero, sign of the numerator.
   function automatic longint fx_div(longint a, longint unsigned d);
      longint unsigned m;
      m = ((a < 0 ? longint'(-a) : a) << FRAC) / d;
      return a < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned rem, root, b;
      rem = x;
      root = 0;
      b = 64'd1 << 62;
      while (b > rem) b >>= 2;
      while (b != 0) begin
         if (rem >= root + b) begin
            rem -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic fbce_rsp_type eval_constraint(fbce_req_type it);
      longint s, g, res, scl, dia;
      longint unsigned k, ms, mg, r;
      bit flag;
      fbce_rsp_type o;
      s = it.separation;
      g = it.multiplier;
      k = it.stiffness;
      flag = 0;
      if (it.is_spring) begin
         scl = ONE_Q;
         if (k == 0) begin
            flag = 1;
            dia = MAX_Q;
            res = (g > 0) ? MAX_Q : (g < 0) ? MIN_Q : s;
         end else begin
            dia = fx_div(ONE_Q, k);
            res = s + fx_div(g, k);
         end
      end else begin
         ms = s < 0 ? -s : s;
         mg = g < 0 ? -g : g;
         r = floor_sqrt(ms * ms + mg * mg);
         res = s + g - longint'(r);
         if ((ms < threshold_q && mg < threshold_q) || r == 0) begin
            scl = 0;
            dia = ONE_Q;
         end else begin
            scl = ONE_Q - fx_div(s, r);
            dia = ONE_Q - fx_div(g, r);
         end
      end
      o.residual = 32'(clip32(res, flag));
      o.scale = 32'(clip32(scl, flag));
      o.diagonal = 32'(clip32(dia, flag));
      o.saturated = flag;
      return o;
   endfunction

   // Receiver: random stall, compare each transfer with the oldest expectation.
   always @(posedge clock) begin
      fbce_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", rsp_payload);
            end else begin
               want = pending_results.pop_front();
               if (rsp_payload !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp res %h scl %h dia %h sat %b, got %h %h %h %b",
                        want.residual, want.scale, want.diagonal, want.saturated,
                        rsp_payload.residual, rsp_payload.scale,
                        rsp_payload.diagonal, rsp_payload.saturated);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Send one constraint; hold it until the transfer happens.
   task automatic send_item(fbce_req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_payload <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(eval_constraint(it));
      items_sent++;
   endtask

   task automatic send_fields(logic [31:0] s, logic [31:0] g, bit sp, logic [30:0] k);
      fbce_req_type it;
      it.separation = s;
      it.multiplier = g;
      it.is_spring = sp;
      it.stiffness = k;
      send_item(it);
   endtask

   // Drain, let the pipeline empty, then write the threshold.
   task automatic write_threshold(logic [THR_W-1:0] v);
      wait_idle();
      csr_valid <= 1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      threshold_q = v;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_q();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($urandom_range(ONE_Q * 4) - ONE_Q * 2);
         2: return $signed($urandom_range(300)) - 150;
         default: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
      endcase
   endfunction

   task automatic test_directed();
      send_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
      send_fields(32'h8000_0000, 32'h8000_0000, 0, 31'h7FFF_FFFF);
      send_fields(32'h8000_0000, 32'h7FFF_FFFF, 0, 5);
      send_fields(0, 0, 0, 0);
      send_fields(0, 0, 1, 0);
      send_fields(5, 32'h0001_0000, 1, 0);
      send_fields(5, 32'hFFFF_0000, 1, 0);
      send_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1);
      send_fields(32'h8000_0000, 32'h8000_0000, 1, 1);
      send_fields(32'h0001_0000, 32'h0002_0000, 1, 31'h7FFF_FFFF);
      send_fields(32'h0001_0000, 32'h0003_0000, 1, 31'h0001_0000);
      send_fields(0, 32'h0001_0000, 0, 0);
      send_fields(32'h0001_0000, 0, 0, 0);
      send_fields(32'hFFFF_0000, 32'h0001_0000, 0, 0);
      send_fields(32'h0003_0000, 32'h0004_0000, 0, 7);
   endtask

   task automatic test_threshold_edges();
      write_threshold(0);
      send_fields(0, 0, 0, 0);
      send_fields(1, 0, 0, 0);
      send_fields(32'hFFFF_FFFF, 1, 0, 0);
      write_threshold(17'h1_0000);
      send_fields(32'h0000_FFFF, 32'hFFFF_0001, 0, 0);
      send_fields(32'h0001_0000, 32'h0000_8000, 0, 0);
      send_fields(32'h0000_8000, 32'h0000_8000, 1, 3);
      write_threshold(17'h1_FFFF);
      send_fields(32'h0001_FFFE, 32'hFFFE_0002, 0, 0);
      send_fields(32'h0001_FFFF, 0, 0, 0);
   endtask

   task automatic test_random(int count, int idle_pct, int stall_pct);
      fbce_req_type it;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) begin
         it.separation = rand_q();
         it.multiplier = rand_q();
         it.is_spring = $urandom_range(2) == 0;
         case ($urandom_range(7))
            0: it.stiffness = 0;
            1: it.stiffness = 31'h7FFF_FFFF;
            2, 3: it.stiffness = 31'($urandom_range(32'h0004_0000, 1));
            default: it.stiffness = 31'($urandom);
         endcase
         send_item(it);
      end
      // Afterwards, no idling on either side.
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      recv_stall_pct = 40;
      test_directed();
      test_threshold_edges();
      write_threshold(17'($urandom_range(17'h1_0000)));
      test_random(280, 17, 81);
      write_threshold(THR_RESET);
      test_random(280, 81, 17);
      write_threshold(17'h0_4000);
      test_random(260, 0, 0);
      wait_idle();
      $display("Covered %0d constraints (springs, collisions, zero stiffness, overflow)",
         items_sent);
      $display("across several near-zero thresholds; %0d results checked", results_seen);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
